[src/lcfd_pkg.sv]
// Shared types, codes and helper functions of the LED cube frame decoder.
package lcfd_pkg;

  localparam logic [1:0] FMT_ONOFF  = 2'd0;
  localparam logic [1:0] FMT_PACKED = 2'd1;
  localparam logic [1:0] FMT_FADE   = 2'd2;

  localparam logic [4:0] LEVEL_FULL = 5'd15;
  localparam logic [4:0] LEVEL_OFF  = 5'd0;

  typedef enum logic [2:0] {
    OP_ONOFF  = 3'b001,
    OP_PACKED = 3'b010,
    OP_FADE   = 3'b100
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [6:0]  position;
    logic [15:0] red_bits;
    logic [15:0] green_bits;
    logic [15:0] blue_bits;
    logic [14:0] packed_color;
  } item_t;

  typedef struct packed {
    op_e         op;
    logic [6:0]  idx;
    logic        red_on;
    logic        green_on;
    logic        blue_on;
    logic [14:0] color;
    logic        last;
  } led_op_t;

  typedef struct packed {
    logic [6:0]  idx;
    logic [14:0] color;
    logic        last;
  } led_wr_t;

  // Nibble of the channel masks that feeds the j-th layer of a group.
  function automatic logic [1:0] nibble_sel(op_e op, logic [1:0] j);
    logic [1:0] nib;
    nib = 2'd0;
    if (op == OP_FADE) begin
      case (j)
        2'd0:    nib = 2'd1;
        2'd1:    nib = 2'd3;
        2'd2:    nib = 2'd0;
        default: nib = 2'd2;
      endcase
    end else begin
      case (j)
        2'd0:    nib = 2'd3;
        2'd1:    nib = 2'd0;
        2'd2:    nib = 2'd2;
        default: nib = 2'd1;
      endcase
    end
    return nib;
  endfunction

  function automatic logic [4:0] fade_level(logic up, logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (up && (v < LEVEL_FULL)) begin
      r = v + 5'd1;
    end else if (!up && (v != LEVEL_OFF)) begin
      r = v - 5'd1;
    end
    return r;
  endfunction

endpackage

[src/lcfd_if.sv]
// Valid/ready channel interfaces for input items, LED writes and configuration.
interface lcfd_in_if;
  logic        valid;
  logic        ready;
  logic [6:0]  position;
  logic [15:0] red_bits;
  logic [15:0] green_bits;
  logic [15:0] blue_bits;
  logic [14:0] packed_color;

  modport source (output valid, output position, output red_bits, output green_bits,
                  output blue_bits, output packed_color, input ready);
  modport sink   (input valid, input position, input red_bits, input green_bits,
                  input blue_bits, input packed_color, output ready);
endinterface

interface lcfd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] layer;
  logic [1:0] column_x;
  logic [1:0] row_y;
  logic [4:0] red_level;
  logic [4:0] green_level;
  logic [4:0] blue_level;
  logic       last;

  modport source (output valid, output layer, output column_x, output row_y,
                  output red_level, output green_level, output blue_level,
                  output last, input ready);
  modport sink   (input valid, input layer, input column_x, input row_y,
                  input red_level, input green_level, input blue_level,
                  input last, output ready);
endinterface

interface lcfd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/led_cube_frame_decoder_unit.sv]
// LED cube frame decoder: turns frame beats into LED writes for an 8x4x4 RGB cube.
//
// The in_i channel takes one frame beat per handshake; cfg_i writes the frame
// format (on/off, packed or fade) and must only be written while the block is idle.
// The out_o channel gives one beat per LED write, with last set on the final
// write caused by an input beat.
// An on/off or fade beat yields 16 writes, one per cycle while the receiver does
// not stall; a packed beat yields one write.
// The sustained rate is set by the single write port of the colour store and
// the one-beat-per-cycle output register.
// An accepted beat passes through the input queue, the stage register and the output register.
// Input beats under an unknown format are accepted and produce nothing.
// The input queue lets the front end keep taking beats while the back end works
// or while the receiver stalls; a stalled receiver holds its beat unchanged.
// At reset the format returns to on/off and every LED reads as off at once;
// no clearing pass is needed.
module led_cube_frame_decoder_unit #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lcfd_in_if.sink     in_i,
  lcfd_cfg_if.sink    cfg_i,
  lcfd_out_if.source  out_o
);
  import lcfd_pkg::*;

  logic  q_push, q_ready, q_valid, q_pop;
  item_t q_in_item, q_out_item;

  lcfd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cfg_i     (cfg_i),
    .q_ready_i (q_ready),
    .q_push_o  (q_push),
    .q_item_o  (q_in_item)
  );

  lcfd_fifo #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (q_out_item),
    .pop_i   (q_pop)
  );

  lcfd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_out_item),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

[src/lcfd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lcfd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/lcfd_fifo.sv]
// Short item queue between the classifying front end and the LED write sequencer.
module lcfd_fifo #(
  parameter int Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lcfd_pkg::item_t item_i,
  output logic            ready_o,
  output logic            valid_o,
  output lcfd_pkg::item_t item_o,
  input  logic            pop_i
);
  import lcfd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != FullCnt);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[src/lcfd_front.sv]
// Front end: holds the frame format register and classifies accepted input beats.
module lcfd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  lcfd_in_if.sink         in_i,
  lcfd_cfg_if.sink        cfg_i,
  input  logic            q_ready_i,
  output logic            q_push_o,
  output lcfd_pkg::item_t q_item_o
);
  import lcfd_pkg::*;

  logic [1:0] format_q;
  logic       known;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= FMT_ONOFF;
    end else if (cfg_i.valid) begin
      format_q <= cfg_i.data;
    end
  end

  always_comb begin
    known         = 1'b1;
    q_item_o.op   = OP_ONOFF;
    case (format_q)
      FMT_ONOFF:  q_item_o.op = OP_ONOFF;
      FMT_PACKED: q_item_o.op = OP_PACKED;
      FMT_FADE:   q_item_o.op = OP_FADE;
      default:    known       = 1'b0;
    endcase
    q_item_o.position     = in_i.position;
    q_item_o.red_bits     = in_i.red_bits;
    q_item_o.green_bits   = in_i.green_bits;
    q_item_o.blue_bits    = in_i.blue_bits;
    q_item_o.packed_color = in_i.packed_color;
  end

  // Beats under an unknown format are taken and dropped.
  assign in_i.ready = q_ready_i;
  assign q_push_o   = in_i.valid && q_ready_i && known;

endmodule

[src/lcfd_back.sv]
// Back end: expands queued items into LED writes against the colour store.
module lcfd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  lcfd_pkg::item_t q_item_i,
  output logic            q_pop_o,
  lcfd_out_if.source      out_o
);
  import lcfd_pkg::*;

  logic [3:0]   k_q, k_d;
  led_op_t      gen;
  led_op_t      a_q;
  logic         a_valid_q, a_valid_d;
  led_wr_t      out_q;
  logic         out_valid_q, out_valid_d;
  logic [127:0] stored_q;
  logic         stored_rd_q;
  logic         fwd_hit_q;
  logic [14:0]  fwd_data_q;
  logic [14:0]  ram_rdata;
  logic [14:0]  cur_color;
  logic [14:0]  new_color;
  logic [6:0]   rd_addr;
  logic         a_adv, a_load, issue;

  always_comb begin
    logic [1:0] j;
    logic [1:0] y;
    logic [3:0] bit_sel;
    j            = k_q[3:2];
    y            = k_q[1:0];
    bit_sel      = {nibble_sel(q_item_i.op, j), ~y};
    gen.op       = q_item_i.op;
    gen.color    = q_item_i.packed_color;
    gen.red_on   = q_item_i.red_bits[bit_sel];
    gen.green_on = q_item_i.green_bits[bit_sel];
    gen.blue_on  = q_item_i.blue_bits[bit_sel];
    if (q_item_i.op == OP_PACKED) begin
      gen.idx  = q_item_i.position;
      gen.last = 1'b1;
    end else begin
      gen.idx  = {~j, q_item_i.position[2], q_item_i.position[1:0], y};
      gen.last = (k_q == 4'd15);
    end
  end

  assign a_adv   = a_valid_q && (!out_valid_q || out_o.ready);
  assign a_load  = !a_valid_q || a_adv;
  assign issue   = q_valid_i && a_load;
  assign q_pop_o = issue && gen.last;
  assign rd_addr = issue ? gen.idx : a_q.idx;

  always_comb begin
    k_d         = k_q;
    a_valid_d   = a_valid_q;
    out_valid_d = out_valid_q;
    if (issue) begin
      k_d = gen.last ? 4'd0 : k_q + 4'd1;
    end
    if (a_load) begin
      a_valid_d = issue;
    end
    if (a_adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  lcfd_ram #(
    .Width (15),
    .Depth (128)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (a_adv),
    .waddr_i (a_q.idx),
    .wdata_i (new_color),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (fwd_hit_q) begin
      cur_color = fwd_data_q;
    end else if (stored_rd_q) begin
      cur_color = ram_rdata;
    end else begin
      cur_color = '0;
    end
  end

  always_comb begin
    new_color = a_q.color;
    case (a_q.op)
      OP_ONOFF: begin
        new_color = {a_q.red_on   ? LEVEL_FULL : LEVEL_OFF,
                     a_q.green_on ? LEVEL_FULL : LEVEL_OFF,
                     a_q.blue_on  ? LEVEL_FULL : LEVEL_OFF};
      end
      OP_FADE: begin
        new_color = {fade_level(a_q.red_on,   cur_color[14:10]),
                     fade_level(a_q.green_on, cur_color[9:5]),
                     fade_level(a_q.blue_on,  cur_color[4:0])};
      end
      default: new_color = a_q.color;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      stored_q    <= '0;
      stored_rd_q <= 1'b0;
      fwd_hit_q   <= 1'b0;
    end else begin
      k_q         <= k_d;
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
      stored_rd_q <= stored_q[rd_addr];
      fwd_hit_q   <= a_adv && (a_q.idx == rd_addr);
      if (a_adv) begin
        stored_q[a_q.idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= new_color;
    if (issue) begin
      a_q <= gen;
    end
    if (a_adv) begin
      out_q.idx   <= a_q.idx;
      out_q.color <= new_color;
      out_q.last  <= a_q.last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.layer       = out_q.idx[6:4];
  assign out_o.column_x    = out_q.idx[3:2];
  assign out_o.row_y       = out_q.idx[1:0];
  assign out_o.red_level   = out_q.color[14:10];
  assign out_o.green_level = out_q.color[9:5];
  assign out_o.blue_level  = out_q.color[4:0];
  assign out_o.last        = out_q.last;

endmodule
